// ===== sv/ppa_pkg.sv =====
`default_nettype none
package ppa_pkg;
	localparam int TRIG_BITS_DEF = 18;
	localparam int COUNT_BITS_DEF = 32;
	localparam int MICROTIME_BITS_DEF = 16;
	localparam int CORDIC_ITERS = 30;
	localparam int IT_W = 5;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] MINUS_ONE_Q28 = -(34'sd1 <<< 28);

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	localparam logic [1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [1:0] REG_MIN_PHOTONS = 2'd1;
	localparam logic [1:0] REG_IRF_REAL = 2'd2;
	localparam logic [1:0] REG_IRF_IMAG = 2'd3;

	// datapath commands from the controller
	typedef struct packed {
		logic load_phase;   // capture microtime, start rotation
		logic rot_step;     // one CORDIC iteration
		logic accum;        // add rounded trig to totals
		logic clear_tot;    // clear totals after a result
		logic mean_start;   // set up mean division
		logic div_step;     // one restoring division step
		logic mean_c_done;  // store cosine mean, load sine mean
		logic mean_s_done;  // store sine mean
		logic mul_a;        // first product pair
		logic mul_b;        // second product pair
		logic num_done;     // form sine numerator and denominator
		logic q_start_g;    // load g quotient
		logic q_start_s;    // load s quotient
		logic q_g_done;
		logic q_s_done;
		logic [IT_W-1:0] iter;
	} ppa_cmd_t;

	typedef struct packed {
		logic count_full;
		logic degen;
		logic too_few;
	} ppa_sts_t;

	function automatic logic [31:0] atan_turn(input logic [IT_W-1:0] i);
		case (i)
			5'd0: atan_turn = 32'h20000000;  5'd1: atan_turn = 32'h12E4051E;
			5'd2: atan_turn = 32'h09FB385B;  5'd3: atan_turn = 32'h051111D4;
			5'd4: atan_turn = 32'h028B0D43;  5'd5: atan_turn = 32'h0145D7E1;
			5'd6: atan_turn = 32'h00A2F61E;  5'd7: atan_turn = 32'h00517C55;
			5'd8: atan_turn = 32'h0028BE53;  5'd9: atan_turn = 32'h00145F2F;
			5'd10: atan_turn = 32'h000A2F98; 5'd11: atan_turn = 32'h000517CC;
			5'd12: atan_turn = 32'h00028BE6; 5'd13: atan_turn = 32'h000145F3;
			5'd14: atan_turn = 32'h0000A2FA; 5'd15: atan_turn = 32'h0000517D;
			5'd16: atan_turn = 32'h000028BE; 5'd17: atan_turn = 32'h0000145F;
			5'd18: atan_turn = 32'h00000A30; 5'd19: atan_turn = 32'h00000518;
			5'd20: atan_turn = 32'h0000028C; 5'd21: atan_turn = 32'h00000146;
			5'd22: atan_turn = 32'h000000A3; 5'd23: atan_turn = 32'h00000051;
			5'd24: atan_turn = 32'h00000029; 5'd25: atan_turn = 32'h00000014;
			5'd26: atan_turn = 32'h0000000A; 5'd27: atan_turn = 32'h00000005;
			5'd28: atan_turn = 32'h00000003; 5'd29: atan_turn = 32'h00000001;
			default: atan_turn = 32'h0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== sv/photon_phasor_accumulator.sv =====
`default_nettype none
// Photon phasor accumulator. Each input word is one photon microtime; its phase
// (microtime * phase_step, 2^32 per turn) is rotated by a 30-step iterative CORDIC
// and the rounded cosine and sine are added to running totals; the next word is
// taken only once that photon is done. On a word with tlast the mean phasor is
// formed by two bit-serial divisions and corrected by the instrument phasor
// through two 92-step divisions (skipped when the set has too few photons or
// the instrument phasor is zero); one result word then waits until taken.
module photon_phasor_accumulator #(
	parameter int TRIG_BITS = ppa_pkg::TRIG_BITS_DEF,
	parameter int COUNT_BITS = ppa_pkg::COUNT_BITS_DEF,
	parameter int MICROTIME_BITS = ppa_pkg::MICROTIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // microtime
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // {phasor_imag, phasor_real}
	output logic [1:0]       m_tuser,   // status
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import ppa_pkg::*;

	logic [31:0] phase_step_q, min_photons_q;
	logic signed [31:0] irf_real_q, irf_imag_q;
	ppa_cmd_t cmd;
	ppa_sts_t sts;
	logic signed [31:0] pr, pi;
	logic in_fire;

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= 32'd65536; min_photons_q <= '0;
			irf_real_q <= 32'sh40000000; irf_imag_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_MIN_PHOTONS: min_photons_q <= cfg_data;
				REG_IRF_REAL: irf_real_q <= cfg_data;
				REG_IRF_IMAG: irf_imag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_fire = s_tvalid && s_tready;

	ppa_ctrl #(.TRIG_BITS(TRIG_BITS), .COUNT_BITS(COUNT_BITS)) u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_tlast), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .status(m_tuser), .cmd, .sts);

	ppa_datapath #(.TRIG_BITS(TRIG_BITS), .COUNT_BITS(COUNT_BITS),
		.MICROTIME_BITS(MICROTIME_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .microtime(s_tdata[MICROTIME_BITS-1:0]),
		.phase_step(phase_step_q), .min_photons(min_photons_q),
		.irf_real(irf_real_q), .irf_imag(irf_imag_q),
		.phasor_real(pr), .phasor_imag(pi));

	assign m_tdata = {pi, pr};
endmodule
`default_nettype wire

// ===== sv/ppa_datapath.sv =====
`default_nettype none
module ppa_datapath #(
	parameter int TRIG_BITS = ppa_pkg::TRIG_BITS_DEF,
	parameter int COUNT_BITS = ppa_pkg::COUNT_BITS_DEF,
	parameter int MICROTIME_BITS = ppa_pkg::MICROTIME_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ppa_pkg::ppa_cmd_t         cmd,
	output ppa_pkg::ppa_sts_t              sts,
	input  wire logic [MICROTIME_BITS-1:0] microtime,
	input  wire logic [31:0]               phase_step,
	input  wire logic [31:0]               min_photons,
	input  wire logic signed [31:0]        irf_real,
	input  wire logic signed [31:0]        irf_imag,
	output logic signed [31:0]             phasor_real,
	output logic signed [31:0]             phasor_imag
);
	import ppa_pkg::*;

	localparam int SH = 31 - TRIG_BITS;
	localparam int SUM_W = TRIG_BITS + COUNT_BITS;
	localparam int MAG_W = SUM_W + SH;
	localparam int QM_W = MAG_W;
	localparam logic signed [33:0] TRIG_MAX = 34'sd2 ** (TRIG_BITS - 1) - 34'sd1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic signed [33:0] x_q, y_q, z_q;
	logic flip_q;
	logic signed [SUM_W-1:0] cos_tot_q, sin_tot_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [MAG_W-1:0] dvd_q;      // dividend shifting out, quotient shifting in
	logic [COUNT_BITS:0] rem_q;
	logic neg_q;
	logic signed [32:0] mc_q, ms_q;
	logic signed [65:0] p1_q, p2_q;
	logic signed [65:0] num_g_q, num_s_q;
	logic [63:0] den_q;
	logic [91:0] qa_q;            // dividend bits then quotient bits
	logic [64:0] qr_q;
	logic qneg_q;

	// phase and rotation
	logic [31:0] phase;
	logic [31:0] p_adj;
	logic signed [33:0] dx, dy, za, xf, yf, c_r, s_r;
	logic [IT_W-1:0] it;
	assign it = cmd.iter;
	assign phase = 32'(({16'd0, 16'(microtime)} * phase_step));
	assign p_adj = (phase >= 32'h40000000 && phase < 32'hC0000000) ?
		phase - 32'h80000000 : phase;
	assign dx = y_q >>> it;
	assign dy = x_q >>> it;
	assign za = {2'b00, atan_turn(it)};
	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;

	function automatic logic signed [33:0] to_trig(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
		if (r > TRIG_MAX) r = TRIG_MAX;
		if (r < -TRIG_MAX) r = -TRIG_MAX;
		to_trig = r;
	endfunction
	assign c_r = to_trig(xf);
	assign s_r = to_trig(yf);

	always_ff @(posedge clk) begin
		if (cmd.load_phase) begin
			flip_q <= (phase >= 32'h40000000 && phase < 32'hC0000000);
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= {{2{p_adj[31]}}, p_adj};
		end else if (cmd.rot_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - za;
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + za;
			end
		end
	end

	// totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_tot_q <= '0; sin_tot_q <= '0; cnt_q <= '0;
		end else if (cmd.clear_tot) begin
			cos_tot_q <= '0; sin_tot_q <= '0; cnt_q <= '0;
		end else if (cmd.accum) begin
			cos_tot_q <= cos_tot_q + SUM_W'(c_r);
			sin_tot_q <= sin_tot_q + SUM_W'(s_r);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.count_full = (cnt_q == COUNT_MAX);
	assign sts.degen = (irf_real == 0) && (irf_imag == 0);
	assign sts.too_few = !(({{(40-COUNT_BITS){1'b0}}, cnt_q} > {8'd0, min_photons}))
		|| (cnt_q == '0);

	// mean division: |sum| << SH / count, one bit a cycle
	logic [MAG_W-1:0] mag_c, mag_s;
	logic [COUNT_BITS:0] rt;
	logic [COUNT_BITS:0] cnt_x;
	assign mag_c = cos_tot_q[SUM_W-1] ? MAG_W'(-cos_tot_q) << SH : MAG_W'(cos_tot_q) << SH;
	assign mag_s = sin_tot_q[SUM_W-1] ? MAG_W'(-sin_tot_q) << SH : MAG_W'(sin_tot_q) << SH;
	assign cnt_x = {1'b0, cnt_q};
	assign rt = {rem_q[COUNT_BITS-1:0], dvd_q[MAG_W-1]};

	logic signed [32:0] mres;
	assign mres = neg_q ? -33'(dvd_q) : 33'(dvd_q);

	always_ff @(posedge clk) begin
		if (cmd.mean_start) begin
			dvd_q <= mag_c; neg_q <= cos_tot_q[SUM_W-1]; rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rt >= cnt_x) begin
				rem_q <= rt - cnt_x; dvd_q <= {dvd_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= rt; dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
			end
		end else if (cmd.mean_c_done) begin
			mc_q <= mres;
			dvd_q <= mag_s; neg_q <= sin_tot_q[SUM_W-1]; rem_q <= '0;
		end else if (cmd.mean_s_done) begin
			ms_q <= mres;
		end
	end

	// products, one pair per cycle
	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			p1_q <= 66'(irf_real * mc_q);
			p2_q <= 66'(irf_imag * ms_q);
		end else if (cmd.mul_b) begin
			num_g_q <= p1_q + p2_q;
			p1_q <= 66'(irf_real * ms_q);
			p2_q <= 66'(irf_imag * mc_q);
		end else if (cmd.num_done) begin
			num_s_q <= p1_q - p2_q;
			den_q <= 64'(irf_real * irf_real) + 64'(irf_imag * irf_imag);
		end
	end

	// quotient: 92 steps over |num| with 28 zero bits appended give floor(|num|*2^28/den)
	logic [63:0] anum_g, anum_s;
	logic [64:0] qrt;
	assign anum_g = num_g_q[65] ? 64'(-num_g_q) : 64'(num_g_q);
	assign anum_s = num_s_q[65] ? 64'(-num_s_q) : 64'(num_s_q);
	assign qrt = {qr_q[63:0], qa_q[91]};

	logic [91:0] qv;
	logic signed [31:0] qres;
	assign qv = qa_q;
	always_comb begin
		if (qv[91:31] != '0) qres = qneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
		else qres = qneg_q ? -32'(qv) : 32'(qv);
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start_g) begin
			qa_q <= {anum_g, 28'd0}; qneg_q <= num_g_q[65]; qr_q <= '0;
		end else if (cmd.q_start_s) begin
			qa_q <= {anum_s, 28'd0}; qneg_q <= num_s_q[65]; qr_q <= '0;
		end else if (cmd.div_step && !cmd.mean_start) begin
			if (qrt >= {1'b0, den_q}) begin
				qr_q <= qrt - {1'b0, den_q}; qa_q <= {qa_q[90:0], 1'b1};
			end else begin
				qr_q <= qrt; qa_q <= {qa_q[90:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_g_done) phasor_real <= qres;
		else if (cmd.mean_start) phasor_real <= 32'(MINUS_ONE_Q28);
		if (cmd.q_s_done) phasor_imag <= qres;
		else if (cmd.mean_start) phasor_imag <= 32'(MINUS_ONE_Q28);
	end
endmodule
`default_nettype wire

// ===== sv/ppa_ctrl.sv =====
`default_nettype none
module ppa_ctrl #(
	parameter int TRIG_BITS = ppa_pkg::TRIG_BITS_DEF,
	parameter int COUNT_BITS = ppa_pkg::COUNT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              in_last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output ppa_pkg::ppa_cmd_t      cmd,
	input  wire ppa_pkg::ppa_sts_t sts
);
	import ppa_pkg::*;

	localparam int MAG_W = TRIG_BITS + COUNT_BITS + 31 - TRIG_BITS;
	localparam int CNT_W = 7;
	localparam logic [3:0] S_IDLE = 4'd0, S_ROT = 4'd1, S_ACC = 4'd2, S_DEC = 4'd3,
		S_MC = 4'd4, S_MS = 4'd5, S_MULA = 4'd6, S_MULB = 4'd7, S_NUM = 4'd8,
		S_QG = 4'd9, S_QS = 4'd10, S_QSD = 4'd11, S_OUT = 4'd12, S_MSD = 4'd13;

	logic [3:0] st_q;
	logic [CNT_W-1:0] n_q;
	logic last_q;

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.iter = n_q[IT_W-1:0];
		cmd.load_phase = in_fire;
		cmd.rot_step = (st_q == S_ROT);
		cmd.accum = (st_q == S_ACC) && !sts.count_full;
		cmd.mean_start = (st_q == S_DEC);
		cmd.div_step = (st_q == S_MC) || (st_q == S_MS) || (st_q == S_QG) || (st_q == S_QS);
		cmd.mean_c_done = (st_q == S_MS) && (n_q == '0);
		cmd.div_step = cmd.div_step && !cmd.mean_c_done;
		cmd.mean_s_done = (st_q == S_MSD);
		cmd.mul_a = (st_q == S_MULA);
		cmd.mul_b = (st_q == S_MULB);
		cmd.num_done = (st_q == S_NUM);
		cmd.q_start_g = (st_q == S_NUM);
		cmd.q_g_done = (st_q == S_QS) && (n_q == '0);
		cmd.q_start_s = cmd.q_g_done;
		cmd.q_s_done = (st_q == S_QSD);
		if (cmd.q_g_done) cmd.div_step = 1'b0;
		cmd.clear_tot = (st_q == S_OUT) && out_ready;
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; n_q <= '0; last_q <= 1'b0; status <= ST_VALID;
		end else begin
			case (st_q)
				S_IDLE: if (in_fire) begin
					st_q <= S_ROT; n_q <= '0; last_q <= in_last;
				end
				S_ROT: begin
					if (n_q == CNT_W'(CORDIC_ITERS - 1)) st_q <= S_ACC;
					else n_q <= n_q + 1'b1;
				end
				S_ACC: st_q <= last_q ? S_DEC : S_IDLE;
				S_DEC: begin
					if (sts.degen) begin status <= ST_DEGEN; st_q <= S_OUT; end
					else if (sts.too_few) begin status <= ST_FEW; st_q <= S_OUT; end
					else begin status <= ST_VALID; st_q <= S_MC; n_q <= CNT_W'(MAG_W - 1); end
				end
				S_MC: begin
					if (n_q == '0) begin st_q <= S_MS; n_q <= '0; end
					else n_q <= n_q - 1'b1;
				end
				S_MS: begin
					if (n_q == '0) n_q <= CNT_W'(MAG_W);
					else if (n_q == 7'd1) begin st_q <= S_MSD; n_q <= '0; end
					else n_q <= n_q - 1'b1;
				end
				S_MSD: st_q <= S_MULA;
				S_MULA: st_q <= S_MULB;
				S_MULB: st_q <= S_NUM;
				S_NUM: begin st_q <= S_QG; n_q <= 7'd91; end
				S_QG: begin
					if (n_q == '0) begin st_q <= S_QS; n_q <= '0; end
					else n_q <= n_q - 1'b1;
				end
				S_QS: begin
					if (n_q == '0) n_q <= 7'd92;
					else if (n_q == 7'd1) begin st_q <= S_QSD; n_q <= '0; end
					else n_q <= n_q - 1'b1;
				end
				S_QSD: st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> last_q) else $error("result without last word");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> st_q == S_IDLE) else $error("word taken while busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_VALID || status == ST_FEW || status == ST_DEGEN))
		else $error("bad status");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import ppa_pkg::*;

	typedef struct packed {
		logic [31:0] g;
		logic [31:0] s;
		logic [1:0]  st;
	} phasor_t;

	localparam longint ANGLE [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
	localparam longint TRIG_LIM = (64'sd1 <<< (TRIG_BITS_DEF - 1)) - 1;
	localparam int MEAN_SH = 31 - TRIG_BITS_DEF;
	localparam int SETTLE = 320;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tlast = 0;
	logic [15:0] s_tdata = '0;
	logic s_tready, m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_PHASE_STEP;
	logic [31:0] cfg_data = '0;

	// shadow registers and totals
	logic [31:0] step_r, min_r;
	longint irf_re, irf_im, cos_sum, sin_sum;
	longint unsigned photons;

	phasor_t phasor_q[$];
	bit calm = 0;
	int errors = 0, words_sent = 0, results_seen = 0;
	int n_valid = 0, n_few = 0, n_degen = 0;

	photon_phasor_accumulator u_top (.*);

	always #5 clk = ~clk;

	function automatic void rotate(input logic [31:0] phase, output longint c,
		output longint sn);
		logic flip;
		logic [31:0] p;
		longint x, y, z, dx, dy;
		flip = 0;
		p = phase;
		x = 64'sd652032874;
		y = 0;
		if (p >= 32'h40000000 && p < 32'hC0000000) begin
			flip = 1;
			p = p - 32'h80000000;
		end
		z = longint'(signed'(p));
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ANGLE[i];
			end else begin
				x += dx; y -= dy; z += ANGLE[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = (x + (64'sd1 <<< (30 - TRIG_BITS_DEF))) >>> (31 - TRIG_BITS_DEF);
		sn = (y + (64'sd1 <<< (30 - TRIG_BITS_DEF))) >>> (31 - TRIG_BITS_DEF);
		if (c > TRIG_LIM) c = TRIG_LIM;
		if (c < -TRIG_LIM) c = -TRIG_LIM;
		if (sn > TRIG_LIM) sn = TRIG_LIM;
		if (sn < -TRIG_LIM) sn = -TRIG_LIM;
	endfunction

	// Q2.30 mean, truncated toward zero
	function automatic longint mean_q30(input longint sum, input longint unsigned n);
		longint unsigned mag, q, r;
		longint a;
		mag = sum < 0 ? longint'(-sum) : sum;
		q = mag / n;
		r = mag % n;
		a = (q << MEAN_SH) + ((r << MEAN_SH) / n);
		return sum < 0 ? -a : a;
	endfunction

	// Q4.28 quotient, truncated toward zero and saturated
	function automatic logic [31:0] quot_q28(input longint num, input longint unsigned den);
		longint unsigned a, q, r;
		a = num < 0 ? longint'(-num) : num;
		q = a / den;
		r = a % den;
		if (q >= 8) begin
			q = 64'h80000000;
		end else begin
			for (int i = 0; i < 28; i++) begin
				r <<= 1;
				q <<= 1;
				if (r >= den) begin
					r -= den; q |= 1;
				end
			end
		end
		if (num >= 0) return q > 64'h7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
		return 32'(-longint'(q));
	endfunction

	// fold one accepted photon into the totals; on the last one queue the phasor
	function automatic void absorb_photon(input logic [15:0] mt, input logic lst);
		longint c, sn, mc, ms;
		longint unsigned m2;
		phasor_t res;
		logic [31:0] ph;
		if (photons < 64'hFFFFFFFF) begin
			ph = 32'(64'(mt) * 64'(step_r));
			rotate(ph, c, sn);
			cos_sum += c;
			sin_sum += sn;
			photons++;
		end
		if (!lst) return;
		res.g = 32'hF0000000;
		res.s = 32'hF0000000;
		if (irf_re == 0 && irf_im == 0) begin
			res.st = ST_DEGEN;
		end else if (photons <= 64'(min_r) || photons == 0) begin
			res.st = ST_FEW;
		end else begin
			mc = mean_q30(cos_sum, photons);
			ms = mean_q30(sin_sum, photons);
			m2 = longint'(irf_re * irf_re) + longint'(irf_im * irf_im);
			res.g = quot_q28(irf_re * mc + irf_im * ms, m2);
			res.s = quot_q28(irf_re * ms - irf_im * mc, m2);
			res.st = ST_VALID;
		end
		phasor_q.push_back(res);
		cos_sum = 0;
		sin_sum = 0;
		photons = 0;
	endfunction

	// compare each result word with the oldest expected phasor
	always @(posedge clk) begin
		phasor_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (phasor_q.size() == 0) begin
				$error("unexpected result word %h status %0d", m_tdata, m_tuser);
				errors++;
			end else begin
				want = phasor_q.pop_front();
				case (want.st)
					ST_VALID: n_valid++;
					ST_FEW: n_few++;
					default: n_degen++;
				endcase
				if (m_tdata[31:0] !== want.g) begin
					$error("phasor_real expected %h got %h", want.g, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== want.s) begin
					$error("phasor_imag expected %h got %h", want.s, m_tdata[63:32]);
					errors++;
				end
				if (m_tuser !== want.st) begin
					$error("status expected %0d got %0d", want.st, m_tuser);
					errors++;
				end
			end
		end
	end

	// stall the result side at random, except in the calm phase
	always @(negedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);

	// send one word; entered and left at a falling edge
	task automatic send_word(input logic [15:0] mt, input logic lst);
		if (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= mt;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		absorb_photon(mt, lst);
		words_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every result is back and the block is quiet
	task automatic drain();
		s_tvalid <= 0;
		while (phasor_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_PHASE_STEP: step_r = val;
			REG_MIN_PHOTONS: min_r = val;
			REG_IRF_REAL: irf_re = longint'(signed'(val));
			default: irf_im = longint'(signed'(val));
		endcase
	endtask

	task automatic set_all(input logic [31:0] st, mn, re, im);
		write_reg(REG_PHASE_STEP, st);
		write_reg(REG_MIN_PHOTONS, mn);
		write_reg(REG_IRF_REAL, re);
		write_reg(REG_IRF_IMAG, im);
	endtask

	task automatic send_set(input int len);
		for (int i = 1; i <= len; i++)
			send_word(16'($urandom), i == len);
	endtask

	// field extremes, reset settings and each special case
	task automatic test_directed();
		send_word(16'h0000, 1);
		send_word(16'hFFFF, 1);
		send_word(16'h5555, 0);
		send_word(16'hAAAA, 0);
		send_word(16'h1234, 1);
		drain();
		set_all(32'h00000000, 32'd2, 32'h40000000, 32'h00000000);
		send_word(16'h00FF, 0);
		send_word(16'hFF00, 1);
		send_word(16'h0001, 0);
		send_word(16'h8000, 0);
		send_word(16'h7FFF, 1);
		drain();
		set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
		send_word(16'hFFFF, 1);
		drain();
		write_reg(REG_MIN_PHOTONS, 32'd0);
		write_reg(REG_IRF_REAL, 32'h80000000);
		write_reg(REG_IRF_IMAG, 32'h7FFFFFFF);
		send_word(16'h4000, 0);
		send_word(16'hC000, 1);
		drain();
		write_reg(REG_PHASE_STEP, 32'd1);
		write_reg(REG_IRF_REAL, 32'd1);
		write_reg(REG_IRF_IMAG, 32'h0);
		send_word(16'h0000, 1);
		drain();
		write_reg(REG_PHASE_STEP, 32'h40000000);
		write_reg(REG_IRF_IMAG, 32'hFFFFFFFF);
		send_word(16'h0003, 1);
		drain();
		write_reg(REG_IRF_REAL, 32'h0);
		write_reg(REG_IRF_IMAG, 32'h80000000);
		send_word(16'h0002, 1);
		drain();
	endtask

	// random settings per phase, mostly short photon sets
	task automatic test_random_sets();
		logic [31:0] st, mn, re, im;
		int len;
		for (int ph = 0; ph < 14; ph++) begin
			calm = (ph == 5);
			case ($urandom_range(3))
				0: st = $urandom_range(1, 2) == 1 ? 32'd1 : 32'hFFFFFFFF;
				1: st = $urandom_range(1, 65536);
				default: st = $urandom;
			endcase
			mn = $urandom_range(9) == 0 ? $urandom : $urandom_range(4);
			case ($urandom_range(4))
				0: begin re = $urandom; im = $urandom; end
				1: begin re = $urandom_range(1, 7); im = 0; end
				2: begin re = 32'h80000000; im = 32'h80000000; end
				default: begin
					re = 32'h40000000 - $urandom_range(0, 32'h1FFFFFFF);
					im = $urandom_range(0, 32'h3FFFFFFF) - 32'h1FFFFFFF;
				end
			endcase
			set_all(st, mn, re, im);
			for (int n = 0; n < 60; n += len) begin
				len = $urandom_range(19) == 0 ? $urandom_range(10, 24) : $urandom_range(1, 6);
				send_set(len);
			end
			drain();
		end
		calm = 0;
	endtask

	initial begin
		step_r = 32'd65536;
		min_r = 0;
		irf_re = 64'sd1 <<< 30;
		irf_im = 0;
		cos_sum = 0;
		sin_sum = 0;
		photons = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_random_sets();
		drain();
		$display("Sent %0d photon words; %0d results checked (%0d valid, %0d too few, %0d degenerate).",
			words_sent, results_seen, n_valid, n_few, n_degen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
